// File: hw/rtl/gec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gec_pkg: shared types and constants of the graphlet extension counter
// Item and result payloads, action and shape codes, controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package gec_pkg;

    // graph size; vertex numbers are 6-bit fields, so rows are 64 bits wide
    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = 6;
    localparam int CFG_W        = 7;
    localparam int CNT_W        = 8;
    localparam int SLICE_W      = 16;
    localparam int NUM_SLICES   = MAX_VERTICES / SLICE_W;
    localparam int SLICE_CNT_W  = $clog2(SLICE_W + 1);
    localparam int PART_W       = $clog2(MAX_VERTICES + 1);
    // accumulator sum with carry for saturation
    localparam int SUM_W        = CNT_W + 1;

    // action codes
    localparam logic [1:0] ACT_CONNECT    = 2'd0;
    localparam logic [1:0] ACT_DISCONNECT = 2'd1;
    localparam logic [1:0] ACT_QUERY      = 2'd2;
    localparam logic [1:0] ACT_COUNT      = 2'd3;

    // base shape codes
    localparam logic [1:0] SHP_TRIANGLE = 2'd0;
    localparam logic [1:0] SHP_PATH     = 2'd1;
    localparam logic [1:0] SHP_EMPTY    = 2'd2;
    localparam logic [1:0] SHP_EDGE     = 2'd3;

    // role rotations: (b,c,a), (c,a,b), (a,b,c)
    localparam logic [1:0] ROT_BCA = 2'd0;
    localparam logic [1:0] ROT_CAB = 2'd1;
    localparam logic [1:0] ROT_ABC = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
        logic [VTX_W-1:0] vertex_c;
        logic [1:0]       base_shape;
        logic [2:0]       neighbor_pattern;
    } t_in_item;

    typedef struct packed {
        logic             edge_present;
        logic [CNT_W-1:0] extension_count;
        logic             range_error;
    } t_out_item;

    typedef enum logic [1:0] {
        RES_ERR,
        RES_EDGE,
        RES_CNT
    } t_res_kind;

    // controller -> datapath
    typedef struct packed {
        logic       load_item;
        logic       rd_c;
        logic       cap_ab;
        logic       cap_c;
        logic       wr_a;
        logic       wr_b;
        logic       cnt_clr;
        logic       part_load;
        logic       acc_add;
        logic [1:0] rot;
        logic       res_load;
        t_res_kind  res_kind;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] action;
        logic       bad;
    } t_dp_sts;

endpackage : gec_pkg
`default_nettype wire

// File: hw/rtl/gec_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gec_datapath: adjacency memory and counting datapath
// Holds the item, the vertex-count register, the adjacency row memory with
// per-row valid bits, the captured rows and the per-rotation popcount and
// accumulator.
// ----------------------------------------------------------------------------
module gec_datapath (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire gec_pkg::t_in_item        i_item,
    input  wire logic                     i_cfg_wr,
    input  wire logic [gec_pkg::CFG_W-1:0] i_cfg_data,
    input  wire gec_pkg::t_dp_cmd         i_cmd,
    output gec_pkg::t_dp_sts              o_sts,
    output gec_pkg::t_out_item            o_result
);
    import gec_pkg::*;

    t_in_item                 r_item;
    logic [CFG_W-1:0]         r_nvtx;
    logic [CFG_W-1:0]         n_eff;

    logic [MAX_VERTICES-1:0]  mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]  r_row_vld;
    logic [MAX_VERTICES-1:0]  r_q0, r_q1;
    logic                     r_qv0, r_qv1;
    logic [VTX_W-1:0]         rd_addr0;
    logic [MAX_VERTICES-1:0]  row0, row1;

    logic                     we;
    logic [VTX_W-1:0]         wr_addr;
    logic [MAX_VERTICES-1:0]  wr_data;
    logic                     set_val;

    logic [MAX_VERTICES-1:0]  r_ra, r_rb, r_rc, r_keep, keep;
    logic [MAX_VERTICES-1:0]  rx, ry, rz, match;
    logic                     e_xy, e_xz, e_yz, fits, rot_used;

    logic [SLICE_CNT_W-1:0]   part_n [NUM_SLICES];
    logic [SLICE_CNT_W-1:0]   r_part [NUM_SLICES];
    logic                     r_part_en;
    logic [PART_W-1:0]        part_sum, part_term;
    logic [CNT_W-1:0]         r_acc;
    logic [SUM_W-1:0]         cnt_total;
    logic [CNT_W-1:0]         cnt_sat;
    t_out_item                n_result;

    function automatic logic [SLICE_CNT_W-1:0] popcnt(input logic [SLICE_W-1:0] v);
        logic [SLICE_CNT_W-1:0] s;
        s = '0;
        for (int i = 0; i < SLICE_W; i++) begin
            s = s + SLICE_CNT_W'(v[i]);
        end
        return s;
    endfunction

    // item and vertex-count register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvtx <= CFG_W'(MAX_VERTICES);
        end else if (i_cfg_wr) begin
            r_nvtx <= i_cfg_data;
        end
    end

    assign n_eff = (r_nvtx > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES) : r_nvtx;

    // range check
    always_comb begin
        o_sts.action = r_item.action;
        o_sts.bad    = ({1'b0, r_item.vertex_a} >= n_eff) ||
                       ({1'b0, r_item.vertex_b} >= n_eff) ||
                       ((r_item.action == ACT_COUNT) && ({1'b0, r_item.vertex_c} >= n_eff));
    end

    // adjacency memory: two read ports, one write port, registered reads
    assign rd_addr0 = i_cmd.rd_c ? r_item.vertex_c : r_item.vertex_a;
    assign set_val  = (r_item.action == ACT_CONNECT);
    assign we       = i_cmd.wr_a | i_cmd.wr_b;
    assign wr_addr  = i_cmd.wr_b ? r_item.vertex_b : r_item.vertex_a;

    always_comb begin
        if (i_cmd.wr_b) begin
            wr_data = r_rb;
            wr_data[r_item.vertex_a] = set_val;
        end else begin
            wr_data = row0;
            wr_data[r_item.vertex_b] = set_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0  <= mem[rd_addr0];
        r_q1  <= mem[r_item.vertex_b];
        r_qv0 <= r_row_vld[rd_addr0];
        r_qv1 <= r_row_vld[r_item.vertex_b];
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // rows never written read as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (we) begin
            r_row_vld[wr_addr] <= 1'b1;
        end
    end

    assign row0 = r_qv0 ? r_q0 : '0;
    assign row1 = r_qv1 ? r_q1 : '0;

    // scan mask: in range, not one of the triple
    always_comb begin
        for (int v = 0; v < MAX_VERTICES; v++) begin
            keep[v] = (CFG_W'(v) < n_eff) &&
                      (VTX_W'(v) != r_item.vertex_a) &&
                      (VTX_W'(v) != r_item.vertex_b) &&
                      (VTX_W'(v) != r_item.vertex_c);
        end
    end

    // row capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_ab) begin
            r_ra <= row0;
            r_rb <= row1;
        end
        if (i_cmd.cap_c) begin
            r_rc   <= row0;
            r_keep <= keep;
        end
    end

    // role selection for the current rotation
    always_comb begin
        unique case (i_cmd.rot)
            ROT_BCA: begin
                rx = r_rb; ry = r_rc; rz = r_ra;
                e_xy = r_rb[r_item.vertex_c];
                e_xz = r_ra[r_item.vertex_b];
                e_yz = r_ra[r_item.vertex_c];
            end
            ROT_CAB: begin
                rx = r_rc; ry = r_ra; rz = r_rb;
                e_xy = r_ra[r_item.vertex_c];
                e_xz = r_rb[r_item.vertex_c];
                e_yz = r_ra[r_item.vertex_b];
            end
            ROT_ABC: begin
                rx = r_ra; ry = r_rb; rz = r_rc;
                e_xy = r_ra[r_item.vertex_b];
                e_xz = r_ra[r_item.vertex_c];
                e_yz = r_rb[r_item.vertex_c];
            end
            default: begin
                rx = '0; ry = '0; rz = '0;
                e_xy = 1'b0; e_xz = 1'b0; e_yz = 1'b0;
            end
        endcase
    end

    always_comb begin
        unique case (r_item.base_shape)
            SHP_TRIANGLE: fits = e_xy & e_xz & e_yz;
            SHP_PATH:     fits = e_xy & e_xz & ~e_yz;
            SHP_EMPTY:    fits = ~e_xy & ~e_xz & ~e_yz;
            SHP_EDGE:     fits = ~e_xy & ~e_xz & e_yz;
            default:      fits = 1'b0;
        endcase
    end

    // triangle and empty use only the (a,b,c) roles
    assign rot_used = (r_item.base_shape == SHP_PATH) || (r_item.base_shape == SHP_EDGE) ||
                      (i_cmd.rot == ROT_ABC);

    assign match = r_keep &
                   ~(rx ^ {MAX_VERTICES{r_item.neighbor_pattern[2]}}) &
                   ~(ry ^ {MAX_VERTICES{r_item.neighbor_pattern[1]}}) &
                   ~(rz ^ {MAX_VERTICES{r_item.neighbor_pattern[0]}});

    always_comb begin
        for (int i = 0; i < NUM_SLICES; i++) begin
            part_n[i] = popcnt(match[i*SLICE_W +: SLICE_W]);
        end
    end

    // slice counts, one rotation per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_clr) begin
            r_part_en <= 1'b0;
        end else if (i_cmd.part_load) begin
            r_part    <= part_n;
            r_part_en <= fits & rot_used;
        end
    end

    always_comb begin
        part_sum = '0;
        for (int i = 0; i < NUM_SLICES; i++) begin
            part_sum = part_sum + PART_W'(r_part[i]);
        end
    end

    assign part_term = r_part_en ? part_sum : '0;
    assign cnt_total = {1'b0, r_acc} + SUM_W'(part_term);
    assign cnt_sat   = cnt_total[CNT_W] ? {CNT_W{1'b1}} : cnt_total[CNT_W-1:0];

    // accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= cnt_sat;
        end
    end

    // next result by kind
    always_comb begin
        n_result = '0;
        unique case (i_cmd.res_kind)
            RES_ERR:  n_result.range_error     = 1'b1;
            RES_EDGE: n_result.edge_present    = row0[r_item.vertex_b];
            RES_CNT:  n_result.extension_count = cnt_sat;
            default:  n_result = '0;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_result <= n_result;
        end
    end

endmodule : gec_datapath
`default_nettype wire

// File: hw/rtl/gec_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gec_ctrl: controller of the graphlet extension counter
// Sequences decode, row reads, mirror writes, the three rotation steps and
// the result strobe.
// ----------------------------------------------------------------------------
module gec_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    output logic                  o_res_strobe,
    input  wire gec_pkg::t_dp_sts i_sts,
    output gec_pkg::t_dp_cmd      o_cmd
);
    import gec_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_RD2,
        S_RD3,
        S_CNT,
        S_FIN,
        S_QRY,
        S_W1,
        S_W2
    } t_state;

    t_state     r_state;
    logic [1:0] r_rot;

    assign o_busy = (r_state != S_IDLE);

    // state, rotation counter and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rot        <= ROT_BCA;
            o_res_strobe <= 1'b0;
        end else begin
            // strobe follows a range error, a query or the end of a count
            o_res_strobe <= ((r_state == S_DEC) && i_sts.bad) ||
                            (r_state == S_FIN) || (r_state == S_QRY);
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (i_sts.bad) begin
                        r_state <= S_IDLE;
                    end else begin
                        unique case (i_sts.action)
                            ACT_CONNECT, ACT_DISCONNECT: r_state <= S_W1;
                            ACT_QUERY:                   r_state <= S_QRY;
                            ACT_COUNT:                   r_state <= S_RD2;
                            default:                     r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RD2: r_state <= S_RD3;
                S_RD3: begin
                    r_state <= S_CNT;
                    r_rot   <= ROT_BCA;
                end
                S_CNT: begin
                    if (r_rot == ROT_ABC) begin
                        r_state <= S_FIN;
                    end else begin
                        r_rot <= r_rot + 2'd1;
                    end
                end
                S_FIN, S_QRY: r_state <= S_IDLE;
                S_W1: r_state <= S_W2;
                S_W2: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.res_kind  = RES_ERR;
        o_cmd.rot       = r_rot;
        o_cmd.load_item = (r_state == S_IDLE) && i_start;
        unique case (r_state)
            S_DEC: begin
                o_cmd.res_load = i_sts.bad;
            end
            S_RD2: begin
                o_cmd.cap_ab  = 1'b1;
                o_cmd.rd_c    = 1'b1;
                o_cmd.cnt_clr = 1'b1;
            end
            S_RD3: o_cmd.cap_c = 1'b1;
            S_CNT: begin
                o_cmd.part_load = 1'b1;
                o_cmd.acc_add   = 1'b1;
            end
            S_FIN: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = RES_CNT;
            end
            S_QRY: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = RES_EDGE;
            end
            S_W1: begin
                o_cmd.wr_a   = 1'b1;
                o_cmd.cap_ab = 1'b1;
            end
            S_W2: o_cmd.wr_b = 1'b1;
            default: o_cmd.load_item = (r_state == S_IDLE) && i_start;
        endcase
    end

    // results are only shown while idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> !o_busy)
        else $error("result strobe while busy");

    // a connect or disconnect gives no result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W2) |=> !o_res_strobe)
        else $error("result after matrix write");

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted request did not start");

    // never two writes in one cycle
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_a && o_cmd.wr_b))
        else $error("two row writes in one cycle");

endmodule : gec_ctrl
`default_nettype wire

// File: hw/rtl/graphlet_extension_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// graphlet_extension_counter: four-node graphlet extension counter
// Adjacency matrix with connect, disconnect, edge query and extension count.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a clock edge with start high and busy low. Its
//   fields are on i_item. Each result appears on o_result for exactly one
//   cycle with o_res_strobe high; the receiver cannot stall it.
//   Connect and disconnect give no result; query, count and any request with
//   a vertex out of range give one.
//   The result strobe comes when busy is already low again, so a new
//   request can be taken while it is high. The count is set by the single
//   pair of row read ports (three rows, captured in S_RD2 and S_RD3) and one
//   rotation per cycle through the popcount unit.
//   The vertex count register is written over i_cfg_valid/o_cfg_ready/
//   i_cfg_data; the user must write it only while idle, as the block itself
//   does not enforce this. o_cfg_ready is always high.
//   Reset (synchronous, active low) empties the graph at once through
//   per-row valid bits and sets the vertex count to 64.
// ----------------------------------------------------------------------------
module graphlet_extension_counter (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire gec_pkg::t_in_item         i_item,
    output logic                           o_res_strobe,
    output gec_pkg::t_out_item             o_result,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [gec_pkg::CFG_W-1:0] i_cfg_data
);
    import gec_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    gec_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .o_res_strobe (o_res_strobe),
        .i_sts        (dp_sts),
        .o_cmd        (dp_cmd)
    );

    gec_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_wr   (i_cfg_valid & o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_result   (o_result)
    );

endmodule : graphlet_extension_counter
`default_nettype wire
